// File: src/assert_macros.svh
// assertion macros shared by the datetime core
// every macro expects signals named clock and reset in the module that uses it
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising edge outside reset
`define EPCD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// same-cycle implication
`define EPCD_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define EPCD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/epcd_pkg.sv
// shared types, constants and helpers of the epoch to calendar datetime core
// no dependencies; the design modules refer to it by scoped names
package epcd_pkg;

   // pipeline layout: stage 0 input, 1..2 day split, 3..9 date and time, 10 output
   localparam int NUM_STAGES = 11;
   localparam int OUT_STAGE  = NUM_STAGES - 1;
   localparam int TAIL_LEN   = 7;

   localparam logic [63:0] EPOCH_MAX_SECONDS = 64'd32536771199;
   localparam int SECS_PER_DAY      = 86400;
   localparam int MARCH_ZERO_SHIFT  = 719468;
   localparam int DAYS_PER_ERA      = 146097;
   localparam int YEARS_PER_ERA     = 400;
   localparam int DAYS_PER_YEAR     = 365;
   localparam int SECS_PER_HOUR     = 3600;
   localparam int SECS_PER_MIN      = 60;
   localparam int YEAR_LIMIT        = 9999;

   localparam int U_W   = 35;
   localparam int SOD_W = 17;
   localparam int Z_W   = 21;
   localparam int Q_W   = 19;
   localparam int DOE_W = 18;

   // 86400 = 675 << 7, so the low 7 bits drop before the reciprocal multiply
   localparam int DAY_PRE_SHIFT = 7;

   // reciprocal constants: m = ceil(2^s / d), s = n + clog2(d), exact for n-bit dividends
   localparam int DAY_N = U_W - DAY_PRE_SHIFT;
   localparam int DAY_D = 675;
   localparam int DAY_S = DAY_N + $clog2(DAY_D);
   localparam logic [31:0] DAY_M =
      32'(((64'd1 << DAY_S) + 64'(DAY_D) - 64'd1) / 64'(DAY_D));

   localparam int ERA_N = Z_W;
   localparam int ERA_S = ERA_N + $clog2(DAYS_PER_ERA);
   localparam logic [31:0] ERA_M =
      32'(((64'd1 << ERA_S) + 64'(DAYS_PER_ERA) - 64'd1) / 64'(DAYS_PER_ERA));

   localparam int Y4_D = 1460;
   localparam int Y4_S = DOE_W + $clog2(Y4_D);
   localparam logic [31:0] Y4_M =
      32'(((64'd1 << Y4_S) + 64'(Y4_D) - 64'd1) / 64'(Y4_D));

   localparam int CENT_D = 36524;
   localparam int CENT_S = DOE_W + $clog2(CENT_D);
   localparam logic [31:0] CENT_M =
      32'(((64'd1 << CENT_S) + 64'(CENT_D) - 64'd1) / 64'(CENT_D));

   localparam int YEAR_S = DOE_W + $clog2(DAYS_PER_YEAR);
   localparam logic [31:0] YEAR_M =
      32'(((64'd1 << YEAR_S) + 64'(DAYS_PER_YEAR) - 64'd1) / 64'(DAYS_PER_YEAR));

   localparam int C100_N = 9;
   localparam int C100_D = 100;
   localparam int C100_S = C100_N + $clog2(C100_D);
   localparam logic [31:0] C100_M =
      32'(((64'd1 << C100_S) + 64'(C100_D) - 64'd1) / 64'(C100_D));

   localparam int MON_N = 12;
   localparam int MON_D = 153;
   localparam int MON_S = MON_N + $clog2(MON_D);
   localparam logic [31:0] MON_M =
      32'(((64'd1 << MON_S) + 64'(MON_D) - 64'd1) / 64'(MON_D));

   localparam int HOUR_S = SOD_W + $clog2(SECS_PER_HOUR);
   localparam logic [31:0] HOUR_M =
      32'(((64'd1 << HOUR_S) + 64'(SECS_PER_HOUR) - 64'd1) / 64'(SECS_PER_HOUR));

   localparam int MIN_N = 12;
   localparam int MIN_S = MIN_N + $clog2(SECS_PER_MIN);
   localparam logic [31:0] MIN_M =
      32'(((64'd1 << MIN_S) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_NULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      logic [3:0] era;
      logic [8:0] yoe;
      logic [8:0] doy;
      logic [3:0] mp;
   } civil_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } tod_type;

   // floor(n / d) through the reciprocal pair of d
   function automatic logic [31:0] div_by_const(input logic [31:0] n,
                                                input logic [31:0] mult,
                                                input int shift);
      logic [63:0] prod;
      prod = 64'(n) * 64'(mult);
      return 32'(prod >> shift);
   endfunction

   // first day of march-based month mp, i.e. (153 * mp + 2) / 5
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] r;
      case (mp)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         4'd12:   r = 9'd367;
         4'd13:   r = 9'd398;
         4'd14:   r = 9'd428;
         4'd15:   r = 9'd459;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

// File: src/epoch_to_calendar_datetime_core.sv
// Converts signed unix seconds plus a null flag into local calendar date and time.
// One word enters per clock while the pipeline is not stalled, and its result leaves through an
// 11-stage pipeline (input stage, two day-split stages, seven date and time stages,
// output register); each stage holds only while the stage after it is full and
// stalled, so bubbles are squeezed out and input stays ready behind a waiting
// result. The constant divides are reciprocal multiplies or shifts. The
// time-zone offset is sampled when a word enters; write it only while idle.
// Depends on epcd_pkg, epcd_day_split, epcd_tod, epcd_civil and assert_macros.svh.
module epoch_to_calendar_datetime_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data,   // tz_offset_minutes, signed
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,     // [63:0] epoch_seconds
   input  logic        req_tuser,     // [0] null_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,     // [13:0] year, [17:14] month, [22:18] day,
                                      // [27:23] hour, [33:28] minute, [39:34] second
   output logic [1:0]  rsp_tuser      // [1:0] status
);

   localparam int OS = epcd_pkg::OUT_STAGE;

   logic [10:0]                    tz_ff;
   logic [epcd_pkg::NUM_STAGES-1:0] valid_ff, valid_in, adv;
   logic                           isnull_ff [0:OS-1];
   logic                           isnull_in;
   logic [epcd_pkg::U_W-1:0]       u_ff, u_in;
   logic [17:0]                    tz_secs;
   logic [epcd_pkg::SOD_W-1:0]     sod;
   logic [epcd_pkg::Z_W-1:0]       z;
   epcd_pkg::tod_type              tod;
   epcd_pkg::civil_type            civ;
   logic [3:0]                     month;
   logic [4:0]                     day;
   logic [13:0]                    year;
   epcd_pkg::status_type           status_in, status_ff;
   logic [39:0]                    data_in, data_ff;

   // a stage may load when it is empty or the one after it is moving
   always_comb begin
      adv[OS] = !valid_ff[OS] || rsp_tready;
      for (int k = OS - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k + 1];
      end
      valid_in[0] = adv[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k <= OS; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k - 1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         tz_ff    <= '0;
      end else begin
         valid_ff <= valid_in;
         if (csr_wr_en) begin
            tz_ff <= csr_wr_data;
         end
      end
   end

   // input stage: range check and local seconds biased by one day
   always_comb begin
      isnull_in = req_tuser || req_tdata[63] || (req_tdata > epcd_pkg::EPOCH_MAX_SECONDS);
      tz_secs   = {{7{tz_ff[10]}}, tz_ff} * 18'd60;
      u_in      = epcd_pkg::U_W'(37'(req_tdata[epcd_pkg::U_W-1:0])
                  + {{19{tz_secs[17]}}, tz_secs}
                  + 37'(epcd_pkg::SECS_PER_DAY));
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         isnull_ff[0] <= isnull_in;
         u_ff         <= u_in;
      end
      for (int k = 1; k < OS; k++) begin
         if (adv[k]) begin
            isnull_ff[k] <= isnull_ff[k - 1];
         end
      end
   end

   epcd_day_split u_split (
      .clock (clock),
      .adv   (adv[2:1]),
      .u     (u_ff),
      .sod   (sod),
      .z     (z)
   );

   epcd_tod u_tod (
      .clock (clock),
      .adv   (adv[OS-1:3]),
      .sod   (sod),
      .tod   (tod)
   );

   epcd_civil u_civil (
      .clock (clock),
      .adv   (adv[OS-1:3]),
      .z     (z),
      .civ   (civ)
   );

   // output stage: month shift, day of month, year and status
   always_comb begin
      month = (civ.mp < 4'd10) ? civ.mp + 4'd3 : civ.mp - 4'd9;
      day   = 5'(civ.doy - epcd_pkg::month_start(civ.mp) + 9'd1);
      year  = 14'(civ.era) * 14'(epcd_pkg::YEARS_PER_ERA) + 14'(civ.yoe)
              + 14'(month <= 4'd2);
      data_in = '0;
      if (isnull_ff[OS-1]) begin
         status_in = epcd_pkg::STATUS_NULL;
      end else if (year > 14'(epcd_pkg::YEAR_LIMIT)) begin
         status_in = epcd_pkg::STATUS_RANGE;
      end else begin
         status_in = epcd_pkg::STATUS_OK;
         data_in   = {tod.second, tod.minute, tod.hour, day, month, year};
      end
   end

   always_ff @(posedge clock) begin
      if (adv[OS]) begin
         status_ff <= status_in;
         data_ff   <= data_in;
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = valid_ff[OS];
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = status_ff;

`include "assert_macros.svh"

   `EPCD_ASSERT_IMPL(a_empty_out_ready, !valid_ff[OS], req_tready, "input blocked with empty output")
   `EPCD_ASSERT_NEXT(a_accept_loads, req_tvalid && req_tready, valid_ff[0], "accepted word lost at input stage")
   `EPCD_ASSERT_IMPL(a_bad_zero, rsp_tvalid && rsp_tuser != epcd_pkg::STATUS_OK, rsp_tdata == '0, "fields not cleared on null or range status")
   `EPCD_ASSERT_IMPL(a_ok_fields, rsp_tvalid && rsp_tuser == epcd_pkg::STATUS_OK, rsp_tdata[17:14] >= 4'd1 && rsp_tdata[17:14] <= 4'd12 && rsp_tdata[22:18] != 5'd0 && rsp_tdata[27:23] <= 5'd23 && rsp_tdata[33:28] <= 6'd59 && rsp_tdata[39:34] <= 6'd59, "date or time field out of range")

endmodule

// File: src/epcd_day_split.sv
// splits biased local seconds into a day number and seconds of day
// depends on epcd_pkg; two pipeline stages
module epcd_day_split (
   input  logic                        clock,
   input  logic [1:0]                  adv,
   input  logic [epcd_pkg::U_W-1:0]    u,
   output logic [epcd_pkg::SOD_W-1:0]  sod,
   output logic [epcd_pkg::Z_W-1:0]    z
);

   logic [epcd_pkg::Q_W-1:0]   q_ff, q_in;
   logic [epcd_pkg::U_W-1:0]   u1_ff;
   logic [epcd_pkg::SOD_W-1:0] sod_ff, sod_in;
   logic [epcd_pkg::Z_W-1:0]   z_ff, z_in;

   // u carries one extra day so it stays positive; q is days + 1
   always_comb begin
      q_in = epcd_pkg::Q_W'(epcd_pkg::div_by_const(
                32'(u[epcd_pkg::U_W-1:epcd_pkg::DAY_PRE_SHIFT]),
                epcd_pkg::DAY_M, epcd_pkg::DAY_S));
      sod_in = epcd_pkg::SOD_W'(u1_ff -
                epcd_pkg::U_W'(q_ff) * epcd_pkg::U_W'(epcd_pkg::SECS_PER_DAY));
      // days + 719468 with the extra day taken back
      z_in = epcd_pkg::Z_W'(q_ff) + epcd_pkg::Z_W'(epcd_pkg::MARCH_ZERO_SHIFT - 1);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         q_ff  <= q_in;
         u1_ff <= u;
      end
      if (adv[1]) begin
         sod_ff <= sod_in;
         z_ff   <= z_in;
      end
   end

   assign sod = sod_ff;
   assign z   = z_ff;

endmodule

// File: src/epcd_tod.sv
// seconds of day to hour, minute and second, delayed to line up with the date path
// depends on epcd_pkg; seven pipeline stages
module epcd_tod (
   input  logic                                clock,
   input  logic [epcd_pkg::TAIL_LEN-1:0]       adv,
   input  logic [epcd_pkg::SOD_W-1:0]          sod,
   output epcd_pkg::tod_type                   tod
);

   logic [epcd_pkg::SOD_W-1:0] sod_ff;
   logic [4:0]                 hour_ff, hour_in, hour2_ff, hour3_ff;
   logic [11:0]                rem_ff, rem_in, rem2_ff;
   logic [5:0]                 minute_ff, minute_in;
   epcd_pkg::tod_type          tod_ff, tod_in;
   epcd_pkg::tod_type          dly_ff [0:2];

   always_comb begin
      hour_in   = 5'(epcd_pkg::div_by_const(32'(sod), epcd_pkg::HOUR_M,
                                            epcd_pkg::HOUR_S));
      rem_in    = 12'(sod_ff - epcd_pkg::SOD_W'(hour_ff) *
                              epcd_pkg::SOD_W'(epcd_pkg::SECS_PER_HOUR));
      minute_in = 6'(epcd_pkg::div_by_const(32'(rem_ff), epcd_pkg::MIN_M,
                                            epcd_pkg::MIN_S));
      tod_in.hour   = hour3_ff;
      tod_in.minute = minute_ff;
      tod_in.second = 6'(rem2_ff - 12'(minute_ff) * 12'(epcd_pkg::SECS_PER_MIN));
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         hour_ff <= hour_in;
         sod_ff  <= sod;
      end
      if (adv[1]) begin
         rem_ff   <= rem_in;
         hour2_ff <= hour_ff;
      end
      if (adv[2]) begin
         minute_ff <= minute_in;
         rem2_ff   <= rem_ff;
         hour3_ff  <= hour2_ff;
      end
      if (adv[3]) begin
         tod_ff <= tod_in;
      end
      if (adv[4]) begin
         dly_ff[0] <= tod_ff;
      end
      if (adv[5]) begin
         dly_ff[1] <= dly_ff[0];
      end
      if (adv[6]) begin
         dly_ff[2] <= dly_ff[1];
      end
   end

   assign tod = dly_ff[2];

endmodule

// File: src/epcd_civil.sv
// shifted day number to era, year of era, day of year and march-based month
// depends on epcd_pkg; seven pipeline stages
module epcd_civil (
   input  logic                           clock,
   input  logic [epcd_pkg::TAIL_LEN-1:0]  adv,
   input  logic [epcd_pkg::Z_W-1:0]       z,
   output epcd_pkg::civil_type            civ
);

   localparam int EW = epcd_pkg::DOE_W + 7;

   logic [3:0]                 era_ff [0:6];
   logic [3:0]                 era_in;
   logic [epcd_pkg::Z_W-1:0]   z_ff;
   logic [epcd_pkg::DOE_W-1:0] doe_ff [1:4];
   logic [epcd_pkg::DOE_W-1:0] doe_in, t_ff, t_in;
   logic [6:0]                 q4y_ff, q4y_in;
   logic [2:0]                 cent_ff, cent_in;
   logic                       last_ff, last_in;
   logic [8:0]                 yoe_ff [4:6];
   logic [8:0]                 yoe_in;
   logic [8:0]                 doy_ff, doy_in, doy2_ff;
   logic [3:0]                 mp_ff, mp_in;
   logic [epcd_pkg::DOE_W-1:0] yday;

   always_comb begin
      era_in  = 4'(epcd_pkg::div_by_const(32'(z), epcd_pkg::ERA_M, epcd_pkg::ERA_S));
      doe_in  = epcd_pkg::DOE_W'(EW'(z_ff) - EW'(era_ff[0]) * EW'(epcd_pkg::DAYS_PER_ERA));
      q4y_in  = 7'(epcd_pkg::div_by_const(32'(doe_ff[1]), epcd_pkg::Y4_M,
                                          epcd_pkg::Y4_S));
      cent_in = 3'(epcd_pkg::div_by_const(32'(doe_ff[1]), epcd_pkg::CENT_M,
                                          epcd_pkg::CENT_S));
      // only the last day of an era reaches 146096
      last_in = (doe_ff[1] == epcd_pkg::DOE_W'(epcd_pkg::DAYS_PER_ERA - 1));
      t_in    = doe_ff[2] - epcd_pkg::DOE_W'(q4y_ff) + epcd_pkg::DOE_W'(cent_ff)
                - epcd_pkg::DOE_W'(last_ff);
      yoe_in  = 9'(epcd_pkg::div_by_const(32'(t_ff), epcd_pkg::YEAR_M, epcd_pkg::YEAR_S));
      // 365 * yoe + yoe / 4 - yoe / 100
      yday    = epcd_pkg::DOE_W'(yoe_ff[4]) * epcd_pkg::DOE_W'(epcd_pkg::DAYS_PER_YEAR)
                + epcd_pkg::DOE_W'(yoe_ff[4][8:2])
                - epcd_pkg::DOE_W'(epcd_pkg::div_by_const(32'(yoe_ff[4]),
                                   epcd_pkg::C100_M, epcd_pkg::C100_S));
      doy_in  = 9'(doe_ff[4] - yday);
      mp_in   = 4'(epcd_pkg::div_by_const(32'(12'(doy_ff) * 12'd5 + 12'd2),
                                          epcd_pkg::MON_M, epcd_pkg::MON_S));
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         era_ff[0] <= era_in;
         z_ff      <= z;
      end
      if (adv[1]) begin
         era_ff[1] <= era_ff[0];
         doe_ff[1] <= doe_in;
      end
      if (adv[2]) begin
         era_ff[2] <= era_ff[1];
         doe_ff[2] <= doe_ff[1];
         q4y_ff    <= q4y_in;
         cent_ff   <= cent_in;
         last_ff   <= last_in;
      end
      if (adv[3]) begin
         era_ff[3] <= era_ff[2];
         doe_ff[3] <= doe_ff[2];
         t_ff      <= t_in;
      end
      if (adv[4]) begin
         era_ff[4] <= era_ff[3];
         doe_ff[4] <= doe_ff[3];
         yoe_ff[4] <= yoe_in;
      end
      if (adv[5]) begin
         era_ff[5] <= era_ff[4];
         yoe_ff[5] <= yoe_ff[4];
         doy_ff    <= doy_in;
      end
      if (adv[6]) begin
         era_ff[6] <= era_ff[5];
         yoe_ff[6] <= yoe_ff[5];
         doy2_ff   <= doy_ff;
         mp_ff     <= mp_in;
      end
   end

   always_comb begin
      civ.era = era_ff[6];
      civ.yoe = yoe_ff[6];
      civ.doy = doy2_ff;
      civ.mp  = mp_ff;
   end

endmodule
